FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the quadratic curve side test.
// No dependencies; included by quadratic_curve_side_test, the file that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, clk_i, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_i, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Implication checked in the cycle after the antecedent, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_i, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/qcst_pkg.sv
// Shared constants and types of the quadratic curve side test.
// No dependencies; used by qcst_wide_mul and the top level.
`default_nettype none

package qcst_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int SIDE_BITS      = 2;
	localparam int CFG_IDX_BITS   = 3;
	localparam int OUT_DATA_BITS  = 8;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_X = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_START_Y = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CTRL_X  = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CTRL_Y  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_END_X   = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_END_Y   = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE    = 3'd6;

	// Side sign codes.
	localparam logic [SIDE_BITS-1:0] SIDE_ZERO = 2'b00;
	localparam logic [SIDE_BITS-1:0] SIDE_POS  = 2'b01;

	// Load enables of the two register stages inside the wide multiplier.
	typedef struct packed {
		logic pp;
		logic sum;
	} mul_en_t;

endpackage

`default_nettype wire

FILE: rtl/qcst_wide_mul.sv
// Two-stage signed multiplier for operands too wide for a single multiplier.
// Depends on qcst_pkg (mul_en_t).
`default_nettype none

module qcst_wide_mul #(
	parameter int W = 37
) (
	input  logic                   clk,
	input  qcst_pkg::mul_en_t      en,
	input  logic signed [W-1:0]    a,
	input  logic signed [W-1:0]    b,
	output logic signed [2*W-1:0]  p
);
	import qcst_pkg::*;

	// Each operand is split into a signed upper half and an unsigned lower half.
	localparam int L  = (W + 1) / 2;
	localparam int H  = W - L;
	localparam int PW = 2 * W;

	logic signed [H-1:0]     ah;
	logic signed [H-1:0]     bh;
	logic        [L-1:0]     al;
	logic        [L-1:0]     bl;
	logic signed [2*H-1:0]   hh_d;
	logic signed [H+L:0]     hl_d;
	logic signed [H+L:0]     lh_d;
	logic        [2*L-1:0]   ll_d;
	logic signed [2*H-1:0]   hh_q;
	logic signed [H+L:0]     hl_q;
	logic signed [H+L:0]     lh_q;
	logic        [2*L-1:0]   ll_q;
	logic signed [PW-1:0]    sum_d;

	assign ah = a[W-1:L];
	assign bh = b[W-1:L];
	assign al = a[L-1:0];
	assign bl = b[L-1:0];

	always_comb begin
		hh_d = ah * bh;
		hl_d = ah * $signed({1'b0, bl});
		lh_d = $signed({1'b0, al}) * bh;
		ll_d = al * bl;
	end

	always_ff @(posedge clk) begin
		if (en.pp) begin
			hh_q <= hh_d;
			hl_q <= hl_d;
			lh_q <= lh_d;
			ll_q <= ll_d;
		end
	end

	assign sum_d = (PW'(hh_q) <<< (2 * L))
		+ ((PW'(hl_q) + PW'(lh_q)) <<< L)
		+ $signed(PW'(ll_q));

	always_ff @(posedge clk) begin
		if (en.sum) begin
			p <= sum_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/quadratic_curve_side_test.sv
// Quadratic curve side test: takes one test point a cycle, while the output is not stalled,
// and reports whether it lies on the configured side of a quadratic Bezier curve, with an
// exact, division-free test. Each word passes through seven register stages from input
// handshake to output register (differences, products, cross products, the sum n1 + 2*n2,
// two stages of split wide multiplication, and the final subtract and sign test). Every
// stage loads when it is empty or the one after it moves, so bubbles close up behind a
// stalled output and nothing is lost or repeated. Control points and the side sign must be
// written through the cfg port only while idle; the block itself does not enforce this.
// Depends on qcst_pkg, qcst_wide_mul and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module quadratic_curve_side_test #(
	parameter int COORD_BITS = qcst_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// point_x, point_y, zero fill
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// inside_res, degenerate, zero fill
	output logic [qcst_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
	input  logic                                   cfg_we,
	input  logic [qcst_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]                  cfg_data
);
	import qcst_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int DW  = C + 1;
	localparam int PW1 = 2 * C + 2;
	localparam int XW  = 2 * C + 3;
	localparam int WW  = 2 * C + 5;
	localparam int QW  = 2 * WW;

	// Configuration registers.
	logic signed [C-1:0]         start_x_q, start_y_q, ctrl_x_q, ctrl_y_q, end_x_q, end_y_q;
	logic        [SIDE_BITS-1:0] side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			ctrl_x_q  <= '0;
			ctrl_y_q  <= '0;
			end_x_q   <= '0;
			end_y_q   <= '0;
			side_q    <= SIDE_POS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_X: start_x_q <= cfg_data;
				CFG_START_Y: start_y_q <= cfg_data;
				CFG_CTRL_X:  ctrl_x_q  <= cfg_data;
				CFG_CTRL_Y:  ctrl_y_q  <= cfg_data;
				CFG_END_X:   end_x_q   <= cfg_data;
				CFG_END_Y:   end_y_q   <= cfg_data;
				CFG_SIDE:    side_q    <= cfg_data[SIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage load enables: a stage moves when it is empty or its successor moves.
	logic [7:1] adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_comb begin
		adv[7] = !vld_s7 || m_axis_tready;
		adv[6] = !vld_s6 || adv[7];
		adv[5] = !vld_s5 || adv[6];
		adv[4] = !vld_s4 || adv[5];
		adv[3] = !vld_s3 || adv[4];
		adv[2] = !vld_s2 || adv[3];
		adv[1] = !vld_s1 || adv[2];
	end

	assign s_axis_tready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv[1]) vld_s1 <= s_axis_tvalid;
			if (adv[2]) vld_s2 <= vld_s1;
			if (adv[3]) vld_s3 <= vld_s2;
			if (adv[4]) vld_s4 <= vld_s3;
			if (adv[5]) vld_s5 <= vld_s4;
			if (adv[6]) vld_s6 <= vld_s5;
			if (adv[7]) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: offsets from the first control point.
	logic signed [C-1:0]  px, py;
	logic signed [DW-1:0] qx_s1, qy_s1, ax_s1, ay_s1, bx_s1, by_s1;

	assign px = s_axis_tdata[C-1:0];
	assign py = s_axis_tdata[2*C-1:C];

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			qx_s1 <= DW'(px) - DW'(start_x_q);
			qy_s1 <= DW'(py) - DW'(start_y_q);
			ax_s1 <= DW'(ctrl_x_q) - DW'(start_x_q);
			ay_s1 <= DW'(ctrl_y_q) - DW'(start_y_q);
			bx_s1 <= DW'(end_x_q) - DW'(start_x_q);
			by_s1 <= DW'(end_y_q) - DW'(start_y_q);
		end
	end

	// Stage 2: the six products of the three cross products.
	logic signed [PW1-1:0] qxby_s2, qybx_s2, axqy_s2, ayqx_s2, axby_s2, aybx_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			qxby_s2 <= qx_s1 * by_s1;
			qybx_s2 <= qy_s1 * bx_s1;
			axqy_s2 <= ax_s1 * qy_s1;
			ayqx_s2 <= ay_s1 * qx_s1;
			axby_s2 <= ax_s1 * by_s1;
			aybx_s2 <= ay_s1 * bx_s1;
		end
	end

	// Stage 3: D, n1 and n2.
	logic signed [XW-1:0] d_s3, n1_s3, n2_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			d_s3  <= XW'(axby_s2) - XW'(aybx_s2);
			n1_s3 <= XW'(qxby_s2) - XW'(qybx_s2);
			n2_s3 <= XW'(axqy_s2) - XW'(ayqx_s2);
		end
	end

	// Stage 4: w = n1 + 2*n2, and the degenerate flag.
	logic signed [WW-1:0] w_s4, n2_s4, d_s4;
	logic                 degen_s4, degen_s5, degen_s6;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			w_s4     <= WW'(n1_s3) + (WW'(n2_s3) <<< 1);
			n2_s4    <= WW'(n2_s3);
			d_s4     <= WW'(d_s3);
			degen_s4 <= (d_s3 == '0);
		end
	end

	// Stages 5 and 6: w*w and n2*D, each as partial products and then their sum.
	mul_en_t              mul_en;
	logic signed [QW-1:0] ww_s6, nd_s6;

	assign mul_en.pp  = adv[5];
	assign mul_en.sum = adv[6];

	qcst_wide_mul #(.W(WW)) u_mul_ww (
		.clk (clk),
		.en  (mul_en),
		.a   (w_s4),
		.b   (w_s4),
		.p   (ww_s6)
	);

	qcst_wide_mul #(.W(WW)) u_mul_nd (
		.clk (clk),
		.en  (mul_en),
		.a   (n2_s4),
		.b   (d_s4),
		.p   (nd_s6)
	);

	always_ff @(posedge clk) begin
		if (adv[5]) degen_s5 <= degen_s4;
		if (adv[6]) degen_s6 <= degen_s5;
	end

	// Stage 7: Q = w*w - 4*n2*D, then its sign against the side sign.
	logic signed [QW-1:0] q_val;
	logic                 q_neg, q_zero, inside_d;
	logic                 inside_s7, degen_s7;

	always_comb begin
		q_val  = ww_s6 - (nd_s6 <<< 2);
		q_neg  = q_val[QW-1];
		q_zero = (q_val == '0);
		if (degen_s6) begin
			inside_d = 1'b0;
		end else if (side_q == SIDE_POS) begin
			inside_d = q_neg;
		end else if (side_q[SIDE_BITS-1]) begin
			inside_d = !q_neg && !q_zero;
		end else begin
			inside_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			inside_s7 <= inside_d;
			degen_s7  <= degen_s6;
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {{(OUT_DATA_BITS-2){1'b0}}, degen_s7, inside_s7};

	// A degenerate curve never reports the point as inside.
	`ASSERT_IMPL(a_degen_not_inside, clk, arst_n, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0], "inside set on degenerate curve")
	// With the output register empty every stage can move, so input must be ready.
	`ASSERT_IMPL(a_ready_when_drained, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output register")
	// A zero side sign never counts any point as inside.
	`ASSERT_IMPL(a_side_zero, clk, arst_n, m_axis_tvalid && side_q == SIDE_ZERO, !m_axis_tdata[0], "inside set with zero side sign")
	// An accepted word always occupies the first stage afterwards.
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_axis_tvalid && s_axis_tready, vld_s1, "accepted word lost at entry")

endmodule

`default_nettype wire
